/* rtl/hsl2rgb_pkg.sv */
package hsl2rgb_pkg;

    localparam int HS_FB  = 12;
    localparam int HS_ONE = 1 << HS_FB;

    localparam int HS_SW = HS_FB + 1;
    localparam int HS_TW = HS_FB + 3;
    localparam int HS_QW = 2 * HS_FB + 1;
    localparam int HS_PW = 3 * HS_FB + 2;
    localparam int HS_VW = 3 * HS_FB + 1;
    localparam int HS_RW = 3 * HS_FB + 10;

    localparam logic [HS_RW-1:0] HS_ONE3 = HS_RW'(1) << (3 * HS_FB);

    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
    } hs_chan_en_t;

endpackage

/* rtl/hsl2rgb_chan.sv */
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
(
    input  logic              clk,
    input  hs_chan_en_t       en,
    input  logic [HS_QW-1:0]  d,
    input  logic [HS_QW-1:0]  p2,
    input  logic [HS_SW-1:0]  f,
    output logic [7:0]        chan
);

    logic [HS_QW-1:0] p2_reg;
    logic [HS_PW-1:0] df_reg;
    logic [HS_PW-1:0] df_next;
    logic [HS_VW-1:0] v3_reg;
    logic [HS_VW-1:0] v3_next;
    logic [7:0]       chan_reg;
    logic [7:0]       chan_next;
    logic [HS_RW-1:0] rnd_sum;
    logic [8:0]       rnd_top;

    assign df_next = HS_PW'(d) * HS_PW'(f);
    assign v3_next = HS_VW'((HS_PW'(p2_reg) << HS_FB) + df_reg);

    always_comb
    begin
        rnd_sum = (HS_RW'(v3_reg) << 9) - (HS_RW'(v3_reg) << 1) + HS_ONE3;
        rnd_top = rnd_sum[HS_RW-1:3*HS_FB+1];
        chan_next = (rnd_top > 9'd255) ? 8'd255 : rnd_top[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            p2_reg <= p2;
            df_reg <= df_next;
        end
        if (en.sum)
        begin
            v3_reg <= v3_next;
        end
        if (en.rnd)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

/* rtl/hsl_to_rgb888_converter_unit.sv */
// Converts one HSL colour per item into an RGB888 colour through a seven-stage pipeline
// that takes a new item in every clock cycle while the output side is not stalled; the
// 25 by 13 bit channel multipliers and the wide rounding adders each have a register
// stage to themselves. Each stage holds its item only while the stage after it is
// full, so a stalled output fills the pipeline's empty stages before the input side is
// held off.
module hsl_to_rgb888_converter_unit
    import hsl2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // hue[11:0], saturation[24:12], lightness[37:25]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int NSTG = 7;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] vld_next;
    logic [NSTG:1] en;

    logic [11:0]       hue;
    logic [12:0]       saturation;
    logic [12:0]       lightness;
    logic [HS_FB-1:0]  h;
    logic [HS_TW-1:0]  t6;
    logic [HS_TW-1:0]  tr_sum;

    logic [HS_SW-1:0]  s1_s_reg, s1_s_next, s1_l_reg, s1_l_next;
    logic [HS_TW-1:0]  s1_tr_reg, s1_tr_next, s1_tg_reg, s1_tb_reg, s1_tb_next;

    logic [HS_QW-1:0]  s2_ls_reg;
    logic [HS_SW-1:0]  s2_s_reg, s2_l_reg;
    logic [HS_SW-1:0]  s2_fr_reg, s2_fg_reg, s2_fb_reg;

    logic [HS_QW-1:0]  s3_q2_reg, s3_q2_next;
    logic [HS_SW-1:0]  s3_l_reg;
    logic [HS_SW-1:0]  s3_fr_reg, s3_fg_reg, s3_fb_reg;

    logic [HS_QW-1:0]  s4_p2_reg, s4_p2_next, s4_d_reg, s4_d_next;
    logic [HS_SW-1:0]  s4_fr_reg, s4_fg_reg, s4_fb_reg;

    hs_chan_en_t       chan_en;
    logic [7:0]        red, green, blue;

    function automatic logic [HS_SW-1:0] seg_frac(input logic [HS_TW-1:0] t);
        logic [HS_SW-1:0] res;
        begin
            priority if (t < HS_TW'(HS_ONE))
                res = HS_SW'(t);
            else if (t < HS_TW'(3 * HS_ONE))
                res = HS_SW'(HS_ONE);
            else if (t < HS_TW'(4 * HS_ONE))
                res = HS_SW'(HS_TW'(4 * HS_ONE) - t);
            else
                res = '0;
            return res;
        end
    endfunction

    always_comb
    begin
        en[NSTG] = !vld_reg[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[1] = en[1] ? s_axis_tvalid : vld_reg[1];
        for (int k = 2; k <= NSTG; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hue        = s_axis_tdata[11:0];
    assign saturation = s_axis_tdata[24:12];
    assign lightness  = s_axis_tdata[37:25];

    always_comb
    begin
        h          = HS_FB'(hue);
        s1_s_next  = (32'(saturation) > HS_ONE) ? HS_SW'(HS_ONE) : HS_SW'(saturation);
        s1_l_next  = (32'(lightness) > HS_ONE) ? HS_SW'(HS_ONE) : HS_SW'(lightness);
        t6         = (HS_TW'(h) << 2) + (HS_TW'(h) << 1);
        tr_sum     = t6 + HS_TW'(2 * HS_ONE);
        s1_tr_next = (tr_sum >= HS_TW'(6 * HS_ONE)) ? tr_sum - HS_TW'(6 * HS_ONE) : tr_sum;
        s1_tb_next = (t6 >= HS_TW'(2 * HS_ONE)) ? t6 - HS_TW'(2 * HS_ONE)
                                                : t6 + HS_TW'(4 * HS_ONE);
    end

    always_comb
    begin
        if ((HS_QW'(s2_l_reg) << 1) < HS_QW'(HS_ONE))
            s3_q2_next = (HS_QW'(s2_l_reg) << HS_FB) + s2_ls_reg;
        else
            s3_q2_next = HS_QW'(((HS_QW + 1)'(s2_l_reg) + (HS_QW + 1)'(s2_s_reg)) << HS_FB)
                         - s2_ls_reg;
    end

    always_comb
    begin
        s4_p2_next = (HS_QW'(s3_l_reg) << (HS_FB + 1)) - s3_q2_reg;
        s4_d_next  = HS_QW'(((HS_QW + 1)'(s3_q2_reg) << 1)
                            - ((HS_QW + 1)'(s3_l_reg) << (HS_FB + 1)));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_s_reg  <= s1_s_next;
            s1_l_reg  <= s1_l_next;
            s1_tr_reg <= s1_tr_next;
            s1_tg_reg <= t6;
            s1_tb_reg <= s1_tb_next;
        end
        if (en[2])
        begin
            s2_ls_reg <= HS_QW'(s1_l_reg) * HS_QW'(s1_s_reg);
            s2_s_reg  <= s1_s_reg;
            s2_l_reg  <= s1_l_reg;
            s2_fr_reg <= seg_frac(s1_tr_reg);
            s2_fg_reg <= seg_frac(s1_tg_reg);
            s2_fb_reg <= seg_frac(s1_tb_reg);
        end
        if (en[3])
        begin
            s3_q2_reg <= s3_q2_next;
            s3_l_reg  <= s2_l_reg;
            s3_fr_reg <= s2_fr_reg;
            s3_fg_reg <= s2_fg_reg;
            s3_fb_reg <= s2_fb_reg;
        end
        if (en[4])
        begin
            s4_p2_reg <= s4_p2_next;
            s4_d_reg  <= s4_d_next;
            s4_fr_reg <= s3_fr_reg;
            s4_fg_reg <= s3_fg_reg;
            s4_fb_reg <= s3_fb_reg;
        end
    end

    assign chan_en.mul = en[5];
    assign chan_en.sum = en[6];
    assign chan_en.rnd = en[7];

    hsl2rgb_chan u_chan_red
    (
        .clk  (clk),
        .en   (chan_en),
        .d    (s4_d_reg),
        .p2   (s4_p2_reg),
        .f    (s4_fr_reg),
        .chan (red)
    );

    hsl2rgb_chan u_chan_green
    (
        .clk  (clk),
        .en   (chan_en),
        .d    (s4_d_reg),
        .p2   (s4_p2_reg),
        .f    (s4_fg_reg),
        .chan (green)
    );

    hsl2rgb_chan u_chan_blue
    (
        .clk  (clk),
        .en   (chan_en),
        .d    (s4_d_reg),
        .p2   (s4_p2_reg),
        .f    (s4_fb_reg),
        .chan (blue)
    );

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = vld_reg[NSTG];
    assign m_axis_tdata  = {blue, green, red};

`ifndef SYNTHESIS
    a_full_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg))
        else $error("Input held off while the pipeline has an empty stage.");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (s3_fr_reg <= HS_SW'(HS_ONE)) && (s3_fg_reg <= HS_SW'(HS_ONE))
                       && (s3_fb_reg <= HS_SW'(HS_ONE)))
        else $error("Segment fraction exceeds one.");

    a_qp_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> ((HS_QW + 1)'(s4_p2_reg) + (HS_QW + 1)'(s4_d_reg))
                       <= ((HS_QW + 1)'(1) << (2 * HS_FB)))
        else $error("q exceeds one or lies below p.");
`endif

endmodule
